// ===== rtl/jccs_pkg.sv =====
package jccs_pkg;

    localparam int RAW_W    = 10;
    localparam int MAP_W    = 11;
    localparam int BTN_W    = 7;
    localparam int SEQ_W    = 32;
    localparam int SUM_W    = 16;
    localparam int TAKEN_W  = 7;
    localparam int DVD_W    = 19;
    localparam int STEP_W   = 5;
    localparam int ADDR_W   = 5;
    localparam int APB_W    = 32;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 104;

    localparam logic [STEP_W-1:0] DIV_LAST = 5'd18;
    localparam logic [MAP_W-1:0]  MID_OUT  = 11'd512;
    localparam logic [MAP_W-1:0]  TOP_OUT  = 11'd1024;
    localparam logic [RAW_W-1:0]  CENTRE_RST = 10'd512;

    localparam logic KIND_CAL  = 1'b0;
    localparam logic KIND_LIVE = 1'b1;

    localparam logic [2:0] REG_AXIS_MAX_X  = 3'd0;
    localparam logic [2:0] REG_AXIS_MAX_Y  = 3'd1;
    localparam logic [2:0] REG_DEAD_LOW_X  = 3'd2;
    localparam logic [2:0] REG_DEAD_HIGH_X = 3'd3;
    localparam logic [2:0] REG_DEAD_LOW_Y  = 3'd4;
    localparam logic [2:0] REG_DEAD_HIGH_Y = 3'd5;
    localparam logic [2:0] REG_CHECK_ON    = 3'd6;

    typedef struct packed {
        logic [RAW_W-1:0] axis_max_x;
        logic [RAW_W-1:0] axis_max_y;
        logic [MAP_W-1:0] dead_low_x;
        logic [MAP_W-1:0] dead_high_x;
        logic [MAP_W-1:0] dead_low_y;
        logic [MAP_W-1:0] dead_high_y;
        logic             check_on;
    } cfg_t;

    typedef struct packed {
        logic             done;
        logic [MAP_W-1:0] mapped;
        logic [RAW_W-1:0] centre_new;
    } lane_res_t;

    typedef enum logic [1:0] {
        L_IDLE,
        L_RUN,
        L_DONE
    } lane_state_t;

    typedef enum logic {
        T_IDLE,
        T_BUSY
    } top_state_t;

endpackage

// ===== rtl/jccs_regs.sv =====
module jccs_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [jccs_pkg::ADDR_W-1:0] paddr,
    input  logic [jccs_pkg::APB_W-1:0]  pwdata,
    output logic [jccs_pkg::APB_W-1:0]  prdata,
    output jccs_pkg::cfg_t             cfg
);

    jccs_pkg::cfg_t cfg_reg;
    logic           wr_en;

    assign wr_en = psel & penable & pwrite;
    assign cfg   = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.axis_max_x  <= 10'd1023;
            cfg_reg.axis_max_y  <= 10'd1023;
            cfg_reg.dead_low_x  <= 11'd500;
            cfg_reg.dead_high_x <= 11'd524;
            cfg_reg.dead_low_y  <= 11'd500;
            cfg_reg.dead_high_y <= 11'd524;
            cfg_reg.check_on    <= 1'b0;
        end else if (wr_en) begin
            case (paddr[4:2])
                jccs_pkg::REG_AXIS_MAX_X:  cfg_reg.axis_max_x  <= pwdata[9:0];
                jccs_pkg::REG_AXIS_MAX_Y:  cfg_reg.axis_max_y  <= pwdata[9:0];
                jccs_pkg::REG_DEAD_LOW_X:  cfg_reg.dead_low_x  <= pwdata[10:0];
                jccs_pkg::REG_DEAD_HIGH_X: cfg_reg.dead_high_x <= pwdata[10:0];
                jccs_pkg::REG_DEAD_LOW_Y:  cfg_reg.dead_low_y  <= pwdata[10:0];
                jccs_pkg::REG_DEAD_HIGH_Y: cfg_reg.dead_high_y <= pwdata[10:0];
                jccs_pkg::REG_CHECK_ON:    cfg_reg.check_on    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            jccs_pkg::REG_AXIS_MAX_X:  prdata = {22'd0, cfg_reg.axis_max_x};
            jccs_pkg::REG_AXIS_MAX_Y:  prdata = {22'd0, cfg_reg.axis_max_y};
            jccs_pkg::REG_DEAD_LOW_X:  prdata = {21'd0, cfg_reg.dead_low_x};
            jccs_pkg::REG_DEAD_HIGH_X: prdata = {21'd0, cfg_reg.dead_high_x};
            jccs_pkg::REG_DEAD_LOW_Y:  prdata = {21'd0, cfg_reg.dead_low_y};
            jccs_pkg::REG_DEAD_HIGH_Y: prdata = {21'd0, cfg_reg.dead_high_y};
            jccs_pkg::REG_CHECK_ON:    prdata = {31'd0, cfg_reg.check_on};
            default:                   prdata = '0;
        endcase
    end

endmodule

// ===== rtl/jccs_lane.sv =====
module jccs_lane #(
    parameter int CAL_SAMPLES = 20
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic                          ack,
    input  logic                          kind,
    input  logic [jccs_pkg::RAW_W-1:0]    raw,
    input  logic [jccs_pkg::RAW_W-1:0]    centre,
    input  logic [jccs_pkg::RAW_W-1:0]    top,
    input  logic [jccs_pkg::SUM_W-1:0]    sum,
    output jccs_pkg::lane_res_t           res
);

    jccs_pkg::lane_state_t state_reg, state_next;

    logic [jccs_pkg::DVD_W-1:0]  dvd_reg;
    logic [jccs_pkg::RAW_W-1:0]  rem_reg;
    logic [jccs_pkg::RAW_W-1:0]  divisor_reg;
    logic [jccs_pkg::STEP_W-1:0] cnt_reg;
    logic                        below_reg;
    logic                        sat_reg;

    logic                        load;
    logic                        below;
    logic [jccs_pkg::RAW_W:0]    trial;
    logic                        ge;
    logic [jccs_pkg::RAW_W-1:0]  upper;

    assign load  = start && (state_reg == jccs_pkg::L_IDLE);
    assign below = raw < centre;
    assign upper = raw - centre;
    assign trial = {rem_reg, dvd_reg[jccs_pkg::DVD_W-1]};
    assign ge    = trial >= {1'b0, divisor_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= jccs_pkg::L_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            jccs_pkg::L_IDLE: if (start) state_next = jccs_pkg::L_RUN;
            jccs_pkg::L_RUN:  if (cnt_reg == jccs_pkg::DIV_LAST) state_next = jccs_pkg::L_DONE;
            jccs_pkg::L_DONE: if (ack) state_next = jccs_pkg::L_IDLE;
            default:          state_next = jccs_pkg::L_IDLE;
        endcase
    end

    // restoring divider, one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (load) begin
            rem_reg   <= '0;
            cnt_reg   <= '0;
            below_reg <= below;
            sat_reg   <= centre >= top;
            if (kind == jccs_pkg::KIND_CAL) begin
                dvd_reg     <= {3'd0, sum};
                divisor_reg <= jccs_pkg::RAW_W'(CAL_SAMPLES);
            end else if (below) begin
                dvd_reg     <= {raw, 9'd0};
                divisor_reg <= centre;
            end else begin
                dvd_reg     <= {upper, 9'd0};
                divisor_reg <= top - centre;
            end
        end else if (state_reg == jccs_pkg::L_RUN) begin
            rem_reg <= ge ? jccs_pkg::RAW_W'(trial - {1'b0, divisor_reg}) : trial[9:0];
            dvd_reg <= {dvd_reg[jccs_pkg::DVD_W-2:0], ge};
            cnt_reg <= cnt_reg + 5'd1;
        end
    end

    always_comb begin
        res.done       = state_reg == jccs_pkg::L_DONE;
        res.centre_new = dvd_reg[9:0];
        if (below_reg) begin
            res.mapped = dvd_reg[10:0];
        end else if (sat_reg || dvd_reg > 19'd512) begin
            res.mapped = jccs_pkg::TOP_OUT;
        end else begin
            res.mapped = dvd_reg[10:0] + jccs_pkg::MID_OUT;
        end
    end

endmodule

// ===== rtl/joystick_center_calibrate_and_scale.sv =====
// s_tready is high only while idle, so a new request is not taken until the last result
// has been moved into the output register; the time spent busy comes from the
// 19-step restoring divider in each axis lane
// both lanes run together; the merge waits for the result register to be free
// reset (aresetn low, synchronous) sets centres to 512, clears sums, counts
// and valid flags, and loads the register defaults
module joystick_center_calibrate_and_scale #(
    parameter int CAL_SAMPLES = 20
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // raw_x, raw_y, button_levels, zero pad
    input  logic [jccs_pkg::S_DATA_W-1:0]   s_tdata,
    // kind
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // mapped_x, mapped_y, pressed, sequence_res, changed, calibrated,
    // centre_x_out, centre_y_out, origin_x, origin_y, zero pad
    output logic [jccs_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [jccs_pkg::ADDR_W-1:0]     paddr,
    input  logic [jccs_pkg::APB_W-1:0]      pwdata,
    output logic [jccs_pkg::APB_W-1:0]      prdata,
    output logic                            pready
);

    jccs_pkg::cfg_t       cfg;
    jccs_pkg::lane_res_t  res_x, res_y;
    jccs_pkg::top_state_t state_reg, state_next;

    logic [jccs_pkg::RAW_W-1:0]   centre_x_reg, centre_y_reg;
    logic [jccs_pkg::SUM_W-1:0]   sum_x_reg, sum_y_reg;
    logic [jccs_pkg::TAKEN_W-1:0] taken_reg;
    logic [jccs_pkg::SEQ_W-1:0]   live_count_reg;
    logic                         cal_hit_reg;
    logic                         kind_reg;
    logic [jccs_pkg::BTN_W-1:0]   btn_reg;
    logic [jccs_pkg::RAW_W-1:0]   raw_x_reg, raw_y_reg;
    logic                         m_tvalid_reg;
    logic [jccs_pkg::M_DATA_W-1:0] m_tdata_reg;

    logic                         s_accept;
    logic                         in_kind;
    logic [jccs_pkg::RAW_W-1:0]   in_raw_x, in_raw_y;
    logic [jccs_pkg::BTN_W-1:0]   in_btn;
    logic [jccs_pkg::SUM_W-1:0]   sum_x_next, sum_y_next;
    logic [jccs_pkg::TAKEN_W-1:0] taken_inc;
    logic                         cal_full;
    logic                         out_free;
    logic                         ack;
    logic                         is_live;
    logic [jccs_pkg::MAP_W-1:0]   mx, my;
    logic [jccs_pkg::BTN_W-1:0]   prs;
    logic                         rest, chg, cal;
    logic [jccs_pkg::RAW_W-1:0]   cx, cy;

    assign in_kind  = s_tuser;
    assign in_raw_x = s_tdata[9:0];
    assign in_raw_y = s_tdata[19:10];
    assign in_btn   = s_tdata[26:20];

    assign pready   = 1'b1;
    assign s_tready = state_reg == jccs_pkg::T_IDLE;
    assign s_accept = s_tvalid && s_tready;

    assign sum_x_next = sum_x_reg + {6'd0, in_raw_x};
    assign sum_y_next = sum_y_reg + {6'd0, in_raw_y};
    assign taken_inc  = taken_reg + 7'd1;
    assign cal_full   = taken_inc >= jccs_pkg::TAKEN_W'(CAL_SAMPLES);

    assign out_free = !m_tvalid_reg || m_tready;
    assign ack      = (state_reg == jccs_pkg::T_BUSY) && res_x.done && res_y.done && out_free;

    jccs_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    jccs_lane #(.CAL_SAMPLES(CAL_SAMPLES)) u_lane_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (s_accept),
        .ack     (ack),
        .kind    (in_kind),
        .raw     (in_raw_x),
        .centre  (centre_x_reg),
        .top     (cfg.axis_max_x),
        .sum     (sum_x_next),
        .res     (res_x)
    );

    jccs_lane #(.CAL_SAMPLES(CAL_SAMPLES)) u_lane_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (s_accept),
        .ack     (ack),
        .kind    (in_kind),
        .raw     (in_raw_y),
        .centre  (centre_y_reg),
        .top     (cfg.axis_max_y),
        .sum     (sum_y_next),
        .res     (res_y)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= jccs_pkg::T_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            jccs_pkg::T_IDLE: if (s_accept) state_next = jccs_pkg::T_BUSY;
            jccs_pkg::T_BUSY: if (ack) state_next = jccs_pkg::T_IDLE;
            default:          state_next = jccs_pkg::T_IDLE;
        endcase
    end

    // running state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            centre_x_reg   <= jccs_pkg::CENTRE_RST;
            centre_y_reg   <= jccs_pkg::CENTRE_RST;
            sum_x_reg      <= '0;
            sum_y_reg      <= '0;
            taken_reg      <= '0;
            live_count_reg <= '0;
            cal_hit_reg    <= 1'b0;
        end else begin
            if (s_accept) begin
                if (in_kind == jccs_pkg::KIND_CAL) begin
                    sum_x_reg   <= cal_full ? '0 : sum_x_next;
                    sum_y_reg   <= cal_full ? '0 : sum_y_next;
                    taken_reg   <= cal_full ? '0 : taken_inc;
                    cal_hit_reg <= cal_full;
                end else begin
                    live_count_reg <= live_count_reg + 32'd1;
                    cal_hit_reg    <= 1'b0;
                end
            end
            if (ack && cal_hit_reg) begin
                centre_x_reg <= res_x.centre_new;
                centre_y_reg <= res_y.centre_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            kind_reg  <= in_kind;
            btn_reg   <= in_btn;
            raw_x_reg <= in_raw_x;
            raw_y_reg <= in_raw_y;
        end
    end

    // merge of the two lanes
    always_comb begin
        is_live = kind_reg == jccs_pkg::KIND_LIVE;
        mx      = is_live ? res_x.mapped : '0;
        my      = is_live ? res_y.mapped : '0;
        prs     = is_live ? ~btn_reg : '0;
        rest    = (cfg.dead_low_x < res_x.mapped) && (res_x.mapped < cfg.dead_high_x) &&
                  (cfg.dead_low_y < res_y.mapped) && (res_y.mapped < cfg.dead_high_y);
        chg     = is_live && (!cfg.check_on || !rest || (prs != '0));
        cal     = !is_live && cal_hit_reg;
        cx      = cal ? res_x.centre_new : centre_x_reg;
        cy      = cal ? res_y.centre_new : centre_y_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ack) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ack) begin
            m_tdata_reg <= {1'b0, raw_y_reg, raw_x_reg, cy, cx, cal, chg,
                            live_count_reg, prs, my, mx};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_lanes_in_step: assert property (@(posedge aclk) disable iff (!aresetn)
        res_x.done == res_y.done)
        else $error("axis lanes out of step");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready && !res_x.done)
        else $error("request taken while a lane is busy");

    a_cal_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && !in_kind && cal_full |=> taken_reg == '0 && cal_hit_reg)
        else $error("calibration count failed to wrap");

    a_result_on_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        ack |=> m_tvalid && s_tready)
        else $error("merged result not presented");

endmodule

// ===== verif/tb_joystick_center_calibrate_and_scale.sv =====
`timescale 1ns / 100ps

module tb_joystick_center_calibrate_and_scale;
    import jccs_pkg::*;

    localparam int         CAL_COUNT     = 20;
    localparam int         SETTLE_CYCLES = 40;
    localparam int         PHASE_COUNT   = 8;
    localparam int         PHASE_ITEMS   = 190;
    localparam logic [2:0] REG_UNUSED    = 3'd7;

    typedef struct packed {
        logic [4:0]       pad;
        logic [BTN_W-1:0] levels;
        logic [RAW_W-1:0] raw_y;
        logic [RAW_W-1:0] raw_x;
    } joy_request_t;

    typedef struct packed {
        logic             pad;
        logic [RAW_W-1:0] origin_y;
        logic [RAW_W-1:0] origin_x;
        logic [RAW_W-1:0] centre_y;
        logic [RAW_W-1:0] centre_x;
        logic             calibrated;
        logic             changed;
        logic [SEQ_W-1:0] sequence_res;
        logic [BTN_W-1:0] pressed;
        logic [MAP_W-1:0] mapped_y;
        logic [MAP_W-1:0] mapped_x;
    } joy_result_t;

    logic                aclk;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                s_tuser  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [ADDR_W-1:0]   paddr    = '0;
    logic [APB_W-1:0]    pwdata   = '0;
    logic [APB_W-1:0]    prdata;
    logic                pready;

    cfg_t              joy_cfg;
    logic [RAW_W-1:0]  centre_x_m;
    logic [RAW_W-1:0]  centre_y_m;
    logic [SUM_W-1:0]  sum_x_m;
    logic [SUM_W-1:0]  sum_y_m;
    logic [TAKEN_W-1:0] taken_m;
    logic [SEQ_W-1:0]  live_total;
    joy_result_t       awaited_results[$];
    int                err_count = 0;
    int                idle_pct  = 0;
    int                stall_pct = 0;

    joystick_center_calibrate_and_scale #(
        .CAL_SAMPLES(CAL_COUNT)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic void reset_model();
        joy_cfg.axis_max_x  = 10'd1023;
        joy_cfg.axis_max_y  = 10'd1023;
        joy_cfg.dead_low_x  = 11'd500;
        joy_cfg.dead_high_x = 11'd524;
        joy_cfg.dead_low_y  = 11'd500;
        joy_cfg.dead_high_y = 11'd524;
        joy_cfg.check_on    = 1'b0;
        centre_x_m = CENTRE_RST;
        centre_y_m = CENTRE_RST;
        sum_x_m    = '0;
        sum_y_m    = '0;
        taken_m    = '0;
        live_total = '0;
    endfunction

    function automatic void apply_write(logic [2:0] idx, logic [APB_W-1:0] val);
        case (idx)
            REG_AXIS_MAX_X:  joy_cfg.axis_max_x  = val[RAW_W-1:0];
            REG_AXIS_MAX_Y:  joy_cfg.axis_max_y  = val[RAW_W-1:0];
            REG_DEAD_LOW_X:  joy_cfg.dead_low_x  = val[MAP_W-1:0];
            REG_DEAD_HIGH_X: joy_cfg.dead_high_x = val[MAP_W-1:0];
            REG_DEAD_LOW_Y:  joy_cfg.dead_low_y  = val[MAP_W-1:0];
            REG_DEAD_HIGH_Y: joy_cfg.dead_high_y = val[MAP_W-1:0];
            REG_CHECK_ON:    joy_cfg.check_on    = val[0];
            default: ;
        endcase
    endfunction

    function automatic logic [MAP_W-1:0] scale_reading(logic [RAW_W-1:0] raw,
                                                       logic [RAW_W-1:0] centre,
                                                       logic [RAW_W-1:0] top);
        int unsigned v;
        if (raw < centre) return MAP_W'((32'(raw) * 32'(MID_OUT)) / 32'(centre));
        if (centre >= top) return TOP_OUT;
        v = (32'(raw - centre) * 32'(MID_OUT)) / 32'(top - centre) + 32'(MID_OUT);
        return (v > 32'(TOP_OUT)) ? TOP_OUT : v[MAP_W-1:0];
    endfunction

    function automatic joy_result_t map_sample(joy_request_t req, logic kind);
        joy_result_t res;
        logic        rest;
        res = '0;
        if (kind == KIND_CAL) begin
            sum_x_m = sum_x_m + SUM_W'(req.raw_x);
            sum_y_m = sum_y_m + SUM_W'(req.raw_y);
            taken_m = taken_m + TAKEN_W'(1);
            if (taken_m >= TAKEN_W'(CAL_COUNT)) begin
                centre_x_m = RAW_W'(sum_x_m / CAL_COUNT);
                centre_y_m = RAW_W'(sum_y_m / CAL_COUNT);
                sum_x_m = '0;
                sum_y_m = '0;
                taken_m = '0;
                res.calibrated = 1'b1;
            end
        end else begin
            live_total   = live_total + SEQ_W'(1);
            res.pressed  = ~req.levels;
            res.mapped_x = scale_reading(req.raw_x, centre_x_m, joy_cfg.axis_max_x);
            res.mapped_y = scale_reading(req.raw_y, centre_y_m, joy_cfg.axis_max_y);
            if (joy_cfg.check_on) begin
                rest = (joy_cfg.dead_low_x < res.mapped_x) && (res.mapped_x < joy_cfg.dead_high_x)
                    && (joy_cfg.dead_low_y < res.mapped_y) && (res.mapped_y < joy_cfg.dead_high_y);
                res.changed = !rest || (res.pressed != '0);
            end else begin
                res.changed = 1'b1;
            end
        end
        res.sequence_res = live_total;
        res.centre_x     = centre_x_m;
        res.centre_y     = centre_y_m;
        res.origin_x     = req.raw_x;
        res.origin_y     = req.raw_y;
        return res;
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s expected %0d got %0d", name, want, got);
            err_count++;
        end
    endfunction

    always @(negedge aclk) begin
        m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        joy_result_t got;
        joy_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = joy_result_t'(m_tdata);
            if (awaited_results.size() == 0) begin
                $error("result with no request awaiting it");
                err_count++;
            end else begin
                want = awaited_results.pop_front();
                compare_field("mapped_x", 32'(want.mapped_x), 32'(got.mapped_x));
                compare_field("mapped_y", 32'(want.mapped_y), 32'(got.mapped_y));
                compare_field("pressed", 32'(want.pressed), 32'(got.pressed));
                compare_field("sequence_res", want.sequence_res, got.sequence_res);
                compare_field("changed", 32'(want.changed), 32'(got.changed));
                compare_field("calibrated", 32'(want.calibrated), 32'(got.calibrated));
                compare_field("centre_x_out", 32'(want.centre_x), 32'(got.centre_x));
                compare_field("centre_y_out", 32'(want.centre_y), 32'(got.centre_y));
                compare_field("origin_x", 32'(want.origin_x), 32'(got.origin_x));
                compare_field("origin_y", 32'(want.origin_y), 32'(got.origin_y));
            end
        end
    end

    task automatic send_sample(logic kind, logic [RAW_W-1:0] rx, logic [RAW_W-1:0] ry,
                               logic [BTN_W-1:0] lv);
        joy_request_t req;
        req = '{pad: '0, levels: lv, raw_y: ry, raw_x: rx};
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= req;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        awaited_results.push_back(map_sample(req, kind));
    endtask

    task automatic wait_results_done();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(logic [2:0] idx, logic [APB_W-1:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        apply_write(idx, val);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [RAW_W-1:0] near_value(int base, int spread);
        int v;
        v = base + int'($urandom_range(2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return v[RAW_W-1:0];
    endfunction

    function automatic logic [RAW_W-1:0] pick_reading(int centre, int top);
        case ($urandom_range(5))
            0: return RAW_W'($urandom_range(1023));
            1: return near_value(centre, 20);
            2: return near_value(top, 8);
            3: return $urandom_range(1) ? 10'd1023 : 10'd0;
            default: return near_value(centre, 120);
        endcase
    endfunction

    function automatic logic [BTN_W-1:0] pick_levels();
        case ($urandom_range(3))
            0, 1: return '1;
            2: return BTN_W'($urandom_range(127));
            default: return ~(7'd1 << $urandom_range(BTN_W - 1));
        endcase
    endfunction

    function automatic logic [APB_W-1:0] pick_axis_max();
        case ($urandom_range(3))
            0: return 1;
            1: return 1023;
            default: return $urandom_range(1, 1023);
        endcase
    endfunction

    function automatic logic [APB_W-1:0] pick_dead_bound();
        case ($urandom_range(4))
            0: return 0;
            1: return 1024;
            default: return $urandom_range(400, 620);
        endcase
    endfunction

    task automatic set_traffic(int idle, int stall);
        idle_pct  = idle;
        stall_pct = stall;
    endtask

    // on odd phases the upper pwdata bits carry noise the block must drop
    task automatic randomise_registers(int phase);
        logic [15:0] noise;
        noise = (phase % 2) ? 16'($urandom) : 16'h0;
        write_register(REG_AXIS_MAX_X, {noise, 16'(pick_axis_max())});
        write_register(REG_AXIS_MAX_Y, {noise, 16'(pick_axis_max())});
        write_register(REG_DEAD_LOW_X, {noise, 16'(pick_dead_bound())});
        write_register(REG_DEAD_HIGH_X, {noise, 16'(pick_dead_bound())});
        write_register(REG_DEAD_LOW_Y, {noise, 16'(pick_dead_bound())});
        write_register(REG_DEAD_HIGH_Y, {noise, 16'(pick_dead_bound())});
        write_register(REG_CHECK_ON, {noise, 16'(phase % 3 != 0)});
    endtask

    task automatic calibrate_run(int len, int base_x, int base_y, int spread);
        repeat (len) begin
            send_sample(KIND_CAL, near_value(base_x, spread), near_value(base_y, spread),
                        pick_levels());
        end
    endtask

    task automatic test_reset_defaults();
        set_traffic(0, 0);
        send_sample(KIND_LIVE, 10'd0, 10'd0, 7'h7F);
        send_sample(KIND_LIVE, 10'd1023, 10'd1023, 7'h00);
        send_sample(KIND_LIVE, 10'd512, 10'd512, 7'h55);
        send_sample(KIND_LIVE, 10'd511, 10'd513, 7'h2A);
        send_sample(KIND_LIVE, 10'd1, 10'd1022, 7'h7E);
    endtask

    task automatic test_dead_box();
        wait_results_done();
        write_register(REG_CHECK_ON, 32'd1);
        send_sample(KIND_LIVE, 10'd512, 10'd512, 7'h7F);
        send_sample(KIND_LIVE, 10'd512, 10'd512, 7'h3F);
        send_sample(KIND_LIVE, 10'd600, 10'd512, 7'h7F);
        send_sample(KIND_LIVE, 10'd512, 10'd400, 7'h7F);
        wait_results_done();
        write_register(REG_UNUSED, 32'hFFFF_FFFF);
        send_sample(KIND_LIVE, 10'd520, 10'd505, 7'h7F);
    endtask

    // centre at the top of the range, then at zero
    task automatic test_centre_extremes();
        wait_results_done();
        write_register(REG_AXIS_MAX_X, 32'd100);
        calibrate_run(CAL_COUNT, 1023, 1023, 0);
        send_sample(KIND_LIVE, 10'd1023, 10'd1023, 7'h7F);
        send_sample(KIND_LIVE, 10'd1000, 10'd0, 7'h7F);
        calibrate_run(CAL_COUNT, 0, 0, 0);
        send_sample(KIND_LIVE, 10'd0, 10'd0, 7'h7F);
        send_sample(KIND_LIVE, 10'd1023, 10'd1023, 7'h00);
        send_sample(KIND_LIVE, 10'd50, 10'd700, 7'h7F);
    endtask

    task automatic test_random_traffic(int phase, int count);
        int sent;
        int r;
        int len;
        int base_x;
        wait_results_done();
        randomise_registers(phase);
        case (phase % 4)
            0: set_traffic(0, 0);
            1: set_traffic(65, 0);
            2: set_traffic(0, 65);
            default: set_traffic(34, 34);
        endcase
        sent = 0;
        while (sent < count) begin
            r = $urandom_range(99);
            if (r < 1) begin
                wait_results_done();
            end else if (r < 5) begin
                len = ($urandom_range(7) == 0) ? $urandom_range(1, CAL_COUNT) : CAL_COUNT;
                base_x = $urandom_range(3) ? $urandom_range(1023) : 1023 * $urandom_range(1);
                calibrate_run(len, base_x, $urandom_range(1023), $urandom_range(40));
                sent += len;
            end else begin
                send_sample(KIND_LIVE,
                            pick_reading(int'(centre_x_m), int'(joy_cfg.axis_max_x)),
                            pick_reading(int'(centre_y_m), int'(joy_cfg.axis_max_y)),
                            pick_levels());
                sent++;
            end
        end
    endtask

    initial begin
        reset_model();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_dead_box();
        test_centre_extremes();
        for (int p = 0; p < PHASE_COUNT; p++) begin
            test_random_traffic(p, PHASE_ITEMS);
        end
        wait_results_done();
        if (err_count == 0 && awaited_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/jccs_pkg.sv
rtl/jccs_regs.sv
rtl/jccs_lane.sv
rtl/joystick_center_calibrate_and_scale.sv
verif/tb_joystick_center_calibrate_and_scale.sv
